// ===== hw/rtl/sidta_pkg.sv =====
package sidta_pkg;

   localparam int MAX_DIGITS  = 10;
   localparam int WORD_DIGITS = 10;
   localparam int BIN_WIDTH   = 32;
   localparam int DIGIT_WIDTH = 4;
   localparam int CHAR_WIDTH  = 6;

   localparam int KEEP_MAX        = (MAX_DIGITS < WORD_DIGITS) ? MAX_DIGITS : WORD_DIGITS;
   localparam int IDX_WIDTH       = $clog2(WORD_DIGITS);
   localparam int SHIFT_CNT_WIDTH = $clog2(BIN_WIDTH);

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

   typedef logic [WORD_DIGITS-1:0][DIGIT_WIDTH-1:0] bcd_vec_type;

   typedef struct packed {
      logic go;
      logic negative;
   } emit_ctrl_type;

endpackage

// ===== hw/rtl/sidta_bcd.sv =====
module sidta_bcd (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic [sidta_pkg::BIN_WIDTH-1:0]   bin,
   output logic                              done,
   output sidta_pkg::bcd_vec_type            bcd
);
   import sidta_pkg::*;

   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [SHIFT_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [BIN_WIDTH-1:0]       bin_ff, bin_in;
   bcd_vec_type                bcd_ff, bcd_in;
   bcd_vec_type                adj;

   // add-3 correction on every digit, then one shift
   always_comb begin
      for (int d = 0; d < WORD_DIGITS; d++) begin
         adj[d] = (bcd_ff[d] >= DIGIT_WIDTH'(5)) ? bcd_ff[d] + DIGIT_WIDTH'(3) : bcd_ff[d];
      end
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (load) begin
         run_in = 1'b1;
         cnt_in = '0;
         bin_in = bin;
         bcd_in = '0;
      end else if (run_ff) begin
         bin_in = {bin_ff[BIN_WIDTH-2:0], 1'b0};
         for (int d = 0; d < WORD_DIGITS; d++) begin
            if (d == 0) begin
               bcd_in[d] = {adj[d][DIGIT_WIDTH-2:0], bin_ff[BIN_WIDTH-1]};
            end else begin
               bcd_in[d] = {adj[d][DIGIT_WIDTH-2:0], adj[d-1][DIGIT_WIDTH-1]};
            end
         end
         cnt_in = cnt_ff + SHIFT_CNT_WIDTH'(1);
         if (cnt_ff == SHIFT_CNT_WIDTH'(BIN_WIDTH - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

// ===== hw/rtl/sidta_emit.sv =====
module sidta_emit (
   input  logic                                clock,
   input  logic                                reset,
   input  sidta_pkg::emit_ctrl_type            ctrl,
   input  sidta_pkg::bcd_vec_type              bcd,
   output logic                                strobe,
   output logic [sidta_pkg::CHAR_WIDTH-1:0]    char_code,
   output logic                                last
);
   import sidta_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_DIGITS
   } state_type;

   state_type             state_ff;
   logic [IDX_WIDTH-1:0]  idx_ff;
   logic                  strobe_ff;
   logic [CHAR_WIDTH-1:0] char_ff;
   logic                  last_ff;
   logic [IDX_WIDTH-1:0]  top_idx;

   // highest significant digit, clamped to the kept width
   always_comb begin
      top_idx = '0;
      for (int d = 0; d < WORD_DIGITS; d++) begin
         if (bcd[d] != '0) begin
            top_idx = IDX_WIDTH'(d);
         end
      end
      if (top_idx > IDX_WIDTH'(KEEP_MAX - 1)) begin
         top_idx = IDX_WIDTH'(KEEP_MAX - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         idx_ff    <= '0;
         char_ff   <= '0;
         last_ff   <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (ctrl.go) begin
                  strobe_ff <= 1'b1;
                  if (ctrl.negative) begin
                     char_ff  <= CHAR_MINUS;
                     last_ff  <= 1'b0;
                     idx_ff   <= top_idx;
                     state_ff <= ST_DIGITS;
                  end else begin
                     char_ff <= CHAR_ZERO + {{(CHAR_WIDTH - DIGIT_WIDTH){1'b0}}, bcd[top_idx]};
                     last_ff <= (top_idx == '0);
                     idx_ff  <= top_idx - IDX_WIDTH'(1);
                     if (top_idx != '0) begin
                        state_ff <= ST_DIGITS;
                     end
                  end
               end
            end
            ST_DIGITS: begin
               strobe_ff <= 1'b1;
               char_ff   <= CHAR_ZERO + {{(CHAR_WIDTH - DIGIT_WIDTH){1'b0}}, bcd[idx_ff]};
               last_ff   <= (idx_ff == '0);
               idx_ff    <= idx_ff - IDX_WIDTH'(1);
               if (idx_ff == '0) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign strobe    = strobe_ff;
   assign char_code = char_ff;
   assign last      = last_ff;

endmodule

// ===== hw/rtl/signed_int_to_decimal_ascii.sv =====
// signed 32-bit integer to decimal ascii text
// input: drive req_value and raise start; the transfer happens at a rising
// edge with start high and busy low. busy stays high until the last
// character of that number has been delivered.
// output: one character per rsp_strobe cycle, most significant first; a
// negative number leads with '-'; rsp_last marks the final character.
// each character is valid for exactly one cycle and must be taken then;
// the receiver has no way to hold results off.
// the magnitude runs through a shift-and-add-3 bcd unit, one bit per cycle;
// once it is done, the emit unit registers the first character and the
// rest follow one per cycle.
// a number of n characters (1 to 11) is paced by the bit-serial bcd loop
// and the one-character-per-cycle output sequencer; a new number is taken
// only in idle, once the last character of the previous one is delivered.
// reset: synchronous, active high; returns to idle, drops busy and
// rsp_strobe; a conversion in progress is abandoned.
module signed_int_to_decimal_ascii (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [sidta_pkg::BIN_WIDTH-1:0] req_value,
   output logic                                rsp_strobe,
   output logic [sidta_pkg::CHAR_WIDTH-1:0]    rsp_char_code,
   output logic                                rsp_last
);
   import sidta_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   state_type            state_ff;
   logic                 negative_ff;
   logic                 accept;
   logic                 bcd_done;
   logic [BIN_WIDTH-1:0] magnitude;
   bcd_vec_type          bcd;
   emit_ctrl_type        emit_ctrl;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign magnitude = req_value[BIN_WIDTH-1] ? (BIN_WIDTH'(0) - req_value) : req_value;

   assign emit_ctrl.go       = (state_ff == ST_CONVERT) && bcd_done;
   assign emit_ctrl.negative = negative_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         negative_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  negative_ff <= req_value[BIN_WIDTH-1];
                  state_ff    <= ST_CONVERT;
               end
            end
            ST_CONVERT: begin
               if (bcd_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (rsp_strobe && rsp_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   sidta_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .load  (accept),
      .bin   (magnitude),
      .done  (bcd_done),
      .bcd   (bcd)
   );

   sidta_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (emit_ctrl),
      .bcd       (bcd),
      .strobe    (rsp_strobe),
      .char_code (rsp_char_code),
      .last      (rsp_last)
   );

endmodule
